[hdl/rbe_pkg.sv]
package rbe_pkg;

   // Operation codes carried in the request tuser field.
   typedef enum logic [2:0] {
      FUNC_INIT    = 3'd0,
      FUNC_GRAY    = 3'd1,
      FUNC_TRANSL  = 3'd2,
      FUNC_INTENS  = 3'd3,
      FUNC_TINT    = 3'd4,
      FUNC_SWAP    = 3'd5
   } func_type;

   // Grayscale method register codes.
   typedef enum logic [1:0] {
      GRAY_NONE     = 2'd0,
      GRAY_LUMA     = 2'd1,
      GRAY_DESAT    = 2'd2,
      GRAY_MAXIMUM  = 2'd3
   } gray_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GRAY_METHOD  = 3'd0;
   localparam logic [2:0] CSR_BLEND_AMOUNT = 3'd1;
   localparam logic [2:0] CSR_TINT_RED     = 3'd2;
   localparam logic [2:0] CSR_TINT_GREEN   = 3'd3;
   localparam logic [2:0] CSR_TINT_BLUE    = 3'd4;

   // RGB565 field layout.
   localparam int RED_SHIFT   = 11;
   localparam int RED_LOSS    = 3;
   localparam int GREEN_SHIFT = 5;
   localparam int GREEN_LOSS  = 2;
   localparam int BLUE_SHIFT  = 0;
   localparam int BLUE_LOSS   = 3;

   // Luminance weights 0.3, 0.59 and 0.11 in Q0.16.
   localparam logic [15:0] COEF_R = 16'd19661;
   localparam logic [15:0] COEF_G = 16'd38666;
   localparam logic [15:0] COEF_B = 16'd7209;

   // 1.0 in Q4.8.
   localparam logic [11:0] AMOUNT_ONE = 12'd256;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Widen one color field of a pixel to 8 bits.
   function automatic logic [7:0] chan_get(input logic [15:0] pix, input int shift,
                                           input int loss);
      logic [15:0] t;
      t = (pix >> shift) & (16'h00FF >> loss);
      chan_get = 8'(t << loss);
   endfunction

   // Narrow an 8-bit-scale value back into its field, saturating on request.
   function automatic logic [15:0] chan_put(input logic [11:0] v, input int shift,
                                            input int loss, input logic sat);
      logic [7:0]  field;
      logic [7:0]  bits;
      logic [15:0] w;
      field = 8'hFF >> loss;
      if (sat && (v > 12'd255)) begin
         bits = field;
      end else begin
         bits = 8'(v >> loss) & field;
      end
      w = 16'(bits);
      chan_put = w << shift;
   endfunction

   // Pack three channel values into an RGB565 word.
   function automatic logic [15:0] pack(input logic [11:0] r, input logic [11:0] g,
                                        input logic [11:0] b, input logic sat);
      pack = chan_put(r, RED_SHIFT, RED_LOSS, sat) |
             chan_put(g, GREEN_SHIFT, GREEN_LOSS, sat) |
             chan_put(b, BLUE_SHIFT, BLUE_LOSS, sat);
   endfunction

   // Channel times a Q4.8 factor, truncated.
   function automatic logic [11:0] scale(input logic [7:0] c, input logic [11:0] f);
      logic [19:0] p;
      p = 20'(c) * 20'(f);
      scale = p[19:8];
   endfunction

   // Mix of tint and source channel, a + inv = 1.0.
   function automatic logic [11:0] tint_mix(input logic [8:0] a, input logic [8:0] inv,
                                            input logic [7:0] t, input logic [7:0] c);
      logic [17:0] s;
      s = 18'(a) * 18'(t) + 18'(inv) * 18'(c);
      tint_mix = 12'(s[17:8]);
   endfunction

   // Luminance term: channel times a Q0.16 weight, truncated.
   function automatic logic [8:0] luma_term(input logic [7:0] c, input logic [15:0] k);
      logic [23:0] p;
      p = 24'(c) * 24'(k);
      luma_term = 9'(p[23:16]);
   endfunction

endpackage

[hdl/rgb565_blend_entry_alu.sv]
// RGB565 blend table entry ALU. One request word carries an operation in
// req_tuser and the entry index plus the current source and destination
// entries in req_tdata; one response word returns both updated entries.
// The block accepts one word every clock cycle while the response side is
// not stalled; each word passes through the input register and then the
// result register, with all channel arithmetic done between the two.
// Either side may stall at any time; the pipeline holds up to two words.
// Configuration writes are taken in any cycle (csr_ready is always high)
// and should be issued only while no words are in flight.
module rgb565_blend_entry_alu (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, lowest bit up: pixel_index[15:0], src_entry[15:0], dst_entry[15:0]
   input  logic [rbe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: func[2:0]
   input  logic [2:0]                       req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, lowest bit up: new_src[15:0], new_dst[15:0]
   output logic [rbe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [2:0]                       csr_index,
   input  logic [11:0]                      csr_data
);
   import rbe_pkg::*;

   logic        gray_method_ff;
   logic [1:0]  gray_sel_ff;
   logic [11:0] amount_ff;
   logic [7:0]  tint_r_ff;
   logic [7:0]  tint_g_ff;
   logic [7:0]  tint_b_ff;

   logic        in_valid_ff;
   logic [2:0]  func_ff;
   logic [15:0] idx_ff;
   logic [15:0] src_ff;
   logic [15:0] dst_ff;

   logic        out_valid_ff;
   logic [15:0] new_src_ff;
   logic [15:0] new_dst_ff;

   logic        out_load;
   logic        in_load;
   logic [15:0] new_src_in;
   logic [15:0] new_dst_in;

   logic [8:0]  amt_a;
   logic [8:0]  amt_inv;
   logic [7:0]  ir, ig, ib;
   logic [7:0]  sr, sg, sb;
   logic [7:0]  mx, mn;
   logic [8:0]  y;
   logic [11:0] y_ext;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_method_ff <= 1'b1;
         gray_sel_ff    <= GRAY_LUMA;
         amount_ff      <= AMOUNT_ONE;
         tint_r_ff      <= '0;
         tint_g_ff      <= '0;
         tint_b_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRAY_METHOD: begin
               gray_sel_ff    <= csr_data[1:0];
               gray_method_ff <= (csr_data[1:0] != GRAY_NONE);
            end
            CSR_BLEND_AMOUNT: amount_ff <= csr_data;
            CSR_TINT_RED:     tint_r_ff <= csr_data[7:0];
            CSR_TINT_GREEN:   tint_g_ff <= csr_data[7:0];
            CSR_TINT_BLUE:    tint_b_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the result register frees when its word is taken, and
   // the input register moves forward whenever the result register frees.
   assign out_load   = !out_valid_ff || rsp_tready;
   assign in_load    = !in_valid_ff || out_load;
   assign req_tready = in_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         func_ff <= req_tuser;
         idx_ff  <= req_tdata[15:0];
         src_ff  <= req_tdata[31:16];
         dst_ff  <= req_tdata[47:32];
      end
   end

   // Widened channels and clamped blend amount.
   always_comb begin
      amt_a   = (amount_ff > AMOUNT_ONE) ? 9'(AMOUNT_ONE) : amount_ff[8:0];
      amt_inv = 9'(AMOUNT_ONE) - amt_a;
      ir = chan_get(idx_ff, RED_SHIFT, RED_LOSS);
      ig = chan_get(idx_ff, GREEN_SHIFT, GREEN_LOSS);
      ib = chan_get(idx_ff, BLUE_SHIFT, BLUE_LOSS);
      sr = chan_get(src_ff, RED_SHIFT, RED_LOSS);
      sg = chan_get(src_ff, GREEN_SHIFT, GREEN_LOSS);
      sb = chan_get(src_ff, BLUE_SHIFT, BLUE_LOSS);
   end

   // Gray value from the index pixel.
   always_comb begin
      mx = (ir > ig) ? ir : ig;
      if (ib > mx) begin
         mx = ib;
      end
      mn = (ir < ig) ? ir : ig;
      if (ib < mn) begin
         mn = ib;
      end
      case (gray_sel_ff)
         GRAY_LUMA:    y = luma_term(ir, COEF_R) + luma_term(ig, COEF_G) +
                           luma_term(ib, COEF_B);
         GRAY_DESAT:   y = 9'((10'(mx) + 10'(mn)) >> 1);
         GRAY_MAXIMUM: y = 9'(mx);
         default:      y = '0;
      endcase
      y_ext = 12'(y);
   end

   // Operation select.
   always_comb begin
      new_src_in = src_ff;
      new_dst_in = dst_ff;
      case (func_ff)
         FUNC_INIT: begin
            new_src_in = idx_ff;
            new_dst_in = '0;
         end
         FUNC_GRAY: begin
            if (gray_method_ff) begin
               new_src_in = pack(y_ext, y_ext, y_ext, 1'b0);
               new_dst_in = '0;
            end
         end
         FUNC_TRANSL: begin
            new_src_in = pack(scale(sr, 12'(amt_inv)), scale(sg, 12'(amt_inv)),
                              scale(sb, 12'(amt_inv)), 1'b0);
            new_dst_in = pack(scale(ir, 12'(amt_a)), scale(ig, 12'(amt_a)),
                              scale(ib, 12'(amt_a)), 1'b0);
         end
         FUNC_INTENS: begin
            new_src_in = pack(scale(sr, amount_ff), scale(sg, amount_ff),
                              scale(sb, amount_ff), 1'b1);
         end
         FUNC_TINT: begin
            new_src_in = pack(tint_mix(amt_a, amt_inv, tint_r_ff, sr),
                              tint_mix(amt_a, amt_inv, tint_g_ff, sg),
                              tint_mix(amt_a, amt_inv, tint_b_ff, sb), 1'b1);
         end
         FUNC_SWAP: begin
            new_src_in = dst_ff;
            new_dst_in = src_ff;
         end
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         new_src_ff <= new_src_in;
         new_dst_ff <= new_dst_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {new_dst_ff, new_src_ff};

endmodule

[hdl/rbe_checker.sv]
module rbe_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rbe_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rbe_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       req_acc;
   logic       rsp_acc;

   // Words accepted but not yet delivered.
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (req_acc && !rsp_acc) begin
         count_in = count_ff + 2'd1;
      end else if (!req_acc && rsp_acc) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled response word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // No response without a word in flight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_ff != 2'd0)
      else $error("response without a pending request");

   // The pipeline never holds more than two words.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("more than two words in flight");

   // An empty block always accepts a request.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> req_tready)
      else $error("request refused while empty");

endmodule

bind rgb565_blend_entry_alu rbe_checker u_rbe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
